@@ hw/rtl/lru_recency_list_defines.svh @@
// Assertion macros for the recency list RTL.
// Included by lru_recency_list to check its own logic; no other dependencies.
`ifndef LRU_RECENCY_LIST_DEFINES_SVH
`define LRU_RECENCY_LIST_DEFINES_SVH
`ifndef ASSERT_OFF
`define LRL_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("lru_recency_list: assertion failed");
`define LRL_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("lru_recency_list: forbidden condition seen");
`else
`define LRL_ASSERT(lbl, clk, rst_n, prop)
`define LRL_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ hw/rtl/lrl_pkg.sv @@
// Shared types and constants for the recency-ordered replacement list.
// Used by lrl_cell, lru_recency_list, the checker and the testbench; depends on nothing else.
package lrl_pkg;

	localparam int KEY_W           = 8;
	localparam int VAL_W           = 8;
	localparam int CNT_W           = 5;
	localparam int MAX_ENTRIES_DEF = 16;
	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic {
		CMD_TOUCH  = 1'b0,
		CMD_INSERT = 1'b1
	} cmd_t;

	// Broadcast from the control logic to every cell.
	typedef struct packed {
		logic             accept;
		logic             insert;
		logic             hit_any;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] count;
	} lrl_bcast_t;

	// Link passed from each cell to its neighbor toward the tail.
	typedef struct packed {
		logic             found;
		logic [VAL_W-1:0] hit_val;
		logic [KEY_W-1:0] tail_key;
		logic [VAL_W-1:0] tail_val;
	} lrl_link_t;

endpackage

@@ hw/rtl/lrl_cell.sv @@
// One position of the recency list: holds a key/value entry and shifts it
// toward the tail. Depends on lrl_pkg for the broadcast and link types.
module lrl_cell #(
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  lrl_pkg::lrl_bcast_t        bc,
	input  logic [lrl_pkg::KEY_W-1:0]  left_key,
	input  logic [lrl_pkg::VAL_W-1:0]  left_val,
	input  lrl_pkg::lrl_link_t         link_i,
	output lrl_pkg::lrl_link_t         link_o,
	output logic [lrl_pkg::KEY_W-1:0]  key_q,
	output logic [lrl_pkg::VAL_W-1:0]  val_q
);

	logic valid;
	logic is_tail;
	logic match;
	logic first;
	logic shift_en;

	assign valid   = int'(bc.count) > IDX;
	assign is_tail = int'(bc.count) == IDX + 1;
	assign match   = valid && (key_q == bc.key);
	assign first   = match && !link_i.found;

	// On a touch hit, every position up to and including the hit moves back.
	assign shift_en = bc.accept && (bc.insert || (bc.hit_any && !link_i.found));

	assign link_o.found    = link_i.found || match;
	assign link_o.hit_val  = link_i.hit_val | (first ? val_q : '0);
	assign link_o.tail_key = link_i.tail_key | (is_tail ? key_q : '0);
	assign link_o.tail_val = link_i.tail_val | (is_tail ? val_q : '0);

	always_ff @(posedge clk) begin
		if (shift_en) begin
			key_q <= left_key;
			val_q <= left_val;
		end
	end

endmodule

@@ hw/rtl/lru_recency_list.sv @@
// Top level of the recency-ordered replacement list: command decode, count,
// capacity register and the row of lrl_cell. Depends on lrl_pkg and defines.
//
//   channel   direction  handshake           word
//   command   in         start, busy         cmd, key_in, value_in
//   result    out        done (strobe)       hit, evicted, evicted_key,
//                                            evicted_value, occupancy
//   config    in         cfg_valid/ready     cfg_data (capacity)
//
// The lookup runs along the cell row and the cells that move shift at the
// accepting edge, so the row's found chain sets the cycle time.
// The result is strobed on done in the cycle after acceptance; busy stays low
// and a new command can be given every cycle. Reset clears the count (list
// empty) and sets capacity to 16; entry storage is not cleared.
`include "lru_recency_list_defines.svh"

module lru_recency_list #(
	parameter int MAX_ENTRIES = lrl_pkg::MAX_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       cmd,
	input  logic [lrl_pkg::KEY_W-1:0]  key_in,
	input  logic [lrl_pkg::VAL_W-1:0]  value_in,
	output logic                       done,
	output logic                       hit,
	output logic                       evicted,
	output logic [lrl_pkg::KEY_W-1:0]  evicted_key,
	output logic [lrl_pkg::VAL_W-1:0]  evicted_value,
	output logic [lrl_pkg::CNT_W-1:0]  occupancy,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [lrl_pkg::CNT_W-1:0]  cfg_data
);

	logic [lrl_pkg::CNT_W-1:0] cap_q;
	logic [lrl_pkg::CNT_W-1:0] count_q;
	logic [lrl_pkg::CNT_W-1:0] cap_eff;
	logic [lrl_pkg::CNT_W-1:0] count_nxt;
	logic                      acc;
	logic                      is_insert;
	logic                      evict;
	logic                      done_q;
	logic                      hit_q;
	logic                      evicted_q;
	logic [lrl_pkg::KEY_W-1:0] ev_key_q;
	logic [lrl_pkg::VAL_W-1:0] ev_val_q;
	logic [lrl_pkg::VAL_W-1:0] head_val;

	lrl_pkg::lrl_bcast_t bc;
	lrl_pkg::lrl_link_t  link [MAX_ENTRIES+1];
	logic [lrl_pkg::KEY_W-1:0] key_st [MAX_ENTRIES];
	logic [lrl_pkg::VAL_W-1:0] val_st [MAX_ENTRIES];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign acc       = start && !busy;
	assign is_insert = (lrl_pkg::cmd_t'(cmd) == lrl_pkg::CMD_INSERT);

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = lrl_pkg::CNT_W'(1);
		end else if (int'(cap_q) > MAX_ENTRIES) begin
			cap_eff = lrl_pkg::CNT_W'(MAX_ENTRIES);
		end else begin
			cap_eff = cap_q;
		end
	end

	// The effective capacity is at least one, so a full list is never empty.
	assign evict = is_insert && (count_q >= cap_eff);

	always_comb begin
		if (is_insert && !evict) begin
			count_nxt = count_q + lrl_pkg::CNT_W'(1);
		end else begin
			count_nxt = count_q;
		end
	end

	assign bc.accept  = acc;
	assign bc.insert  = is_insert;
	assign bc.hit_any = link[MAX_ENTRIES].found;
	assign bc.key     = key_in;
	assign bc.count   = count_q;

	// A touch hit brings the found value to the front with the same key.
	assign head_val = is_insert ? value_in : link[MAX_ENTRIES].hit_val;

	assign link[0] = '0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_head
			lrl_cell #(.IDX(i)) u_cell (
				.clk      (clk),
				.bc       (bc),
				.left_key (key_in),
				.left_val (head_val),
				.link_i   (link[i]),
				.link_o   (link[i+1]),
				.key_q    (key_st[i]),
				.val_q    (val_st[i])
			);
		end else begin : g_body
			lrl_cell #(.IDX(i)) u_cell (
				.clk      (clk),
				.bc       (bc),
				.left_key (key_st[i-1]),
				.left_val (val_st[i-1]),
				.link_i   (link[i]),
				.link_o   (link[i+1]),
				.key_q    (key_st[i]),
				.val_q    (val_st[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= lrl_pkg::CAP_RESET;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (acc) begin
				count_q <= count_nxt;
			end
			done_q <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			hit_q     <= !is_insert && link[MAX_ENTRIES].found;
			evicted_q <= evict;
			ev_key_q  <= evict ? link[MAX_ENTRIES].tail_key : '0;
			ev_val_q  <= evict ? link[MAX_ENTRIES].tail_val : '0;
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign evicted       = evicted_q;
	assign evicted_key   = ev_key_q;
	assign evicted_value = ev_val_q;
	assign occupancy     = count_q;

	`LRL_ASSERT_NEVER(a_count_max, clk, arst_n, int'(count_q) > MAX_ENTRIES)
	`LRL_ASSERT(a_done_follows, clk, arst_n, acc |=> done)
	`LRL_ASSERT(a_done_only_acc, clk, arst_n, !acc |=> !done)
	`LRL_ASSERT(a_touch_keeps, clk, arst_n, acc && !is_insert |=> !evicted && occupancy == $past(count_q))
	`LRL_ASSERT_NEVER(a_hit_and_evict, clk, arst_n, done && hit && evicted)
	`LRL_ASSERT(a_full_tail, clk, arst_n, acc && evict && int'(count_q) == MAX_ENTRIES |=> evicted_key == $past(key_st[MAX_ENTRIES-1]))

endmodule

@@ dv/lru_recency_list_checker.sv @@
// Checker for lru_recency_list: watches the command, config and result channels.
// Keeps its own copy of the recency order and compares every result word.
// Depends on lrl_pkg.
module lru_recency_list_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic                       cmd,
	input  logic [lrl_pkg::KEY_W-1:0]  key_in,
	input  logic [lrl_pkg::VAL_W-1:0]  value_in,
	input  logic                       done,
	input  logic                       hit,
	input  logic                       evicted,
	input  logic [lrl_pkg::KEY_W-1:0]  evicted_key,
	input  logic [lrl_pkg::VAL_W-1:0]  evicted_value,
	input  logic [lrl_pkg::CNT_W-1:0]  occupancy,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [lrl_pkg::CNT_W-1:0]  cfg_data,
	output int                         mismatches,
	output int                         outstanding
);
	localparam int DEPTH = lrl_pkg::MAX_ENTRIES_DEF;

	typedef struct packed {
		logic                      hit;
		logic                      evicted;
		logic [lrl_pkg::KEY_W-1:0] ekey;
		logic [lrl_pkg::VAL_W-1:0] evalue;
		logic [lrl_pkg::CNT_W-1:0] occ;
	} access_outcome_t;

	logic [lrl_pkg::KEY_W-1:0] order_key [DEPTH];
	logic [lrl_pkg::VAL_W-1:0] order_val [DEPTH];
	int held;
	int cap_reg;
	access_outcome_t awaited_outcomes[$];
	access_outcome_t want;

	// Position 0 is the most recent entry; only positions below held are read.
	function automatic access_outcome_t predict_access(lrl_pkg::cmd_t op,
			logic [lrl_pkg::KEY_W-1:0] k, logic [lrl_pkg::VAL_W-1:0] v);
		access_outcome_t o;
		int eff;
		int pos;
		logic [lrl_pkg::VAL_W-1:0] moved_val;
		o = '0;
		eff = (cap_reg < 1) ? 1 : ((cap_reg > DEPTH) ? DEPTH : cap_reg);
		if (op == lrl_pkg::CMD_INSERT) begin
			// Only the single oldest entry goes, even if capacity was lowered below held.
			if (held + 1 > eff && held > 0) begin
				o.evicted = 1'b1;
				o.ekey = order_key[held-1];
				o.evalue = order_val[held-1];
				held--;
			end
			for (int i = held; i > 0; i--) begin
				if (i < DEPTH) begin
					order_key[i] = order_key[i-1];
					order_val[i] = order_val[i-1];
				end
			end
			order_key[0] = k;
			order_val[0] = v;
			held++;
		end else begin
			pos = held;
			for (int i = held - 1; i >= 0; i--) begin
				if (order_key[i] == k)
					pos = i;
			end
			if (pos < held) begin
				moved_val = order_val[pos];
				o.hit = 1'b1;
				for (int i = pos; i > 0; i--) begin
					order_key[i] = order_key[i-1];
					order_val[i] = order_val[i-1];
				end
				order_key[0] = k;
				order_val[0] = moved_val;
			end
		end
		o.occ = held[lrl_pkg::CNT_W-1:0];
		return o;
	endfunction

	task automatic check_field(string name, int unsigned want_v, int unsigned got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			cap_reg = int'(lrl_pkg::CAP_RESET);
			awaited_outcomes.delete();
			outstanding = 0;
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				cap_reg = int'(cfg_data);
			// Queue the new word first so a same-edge result still pops the oldest.
			if (start && !busy)
				awaited_outcomes.push_back(predict_access(lrl_pkg::cmd_t'(cmd), key_in,
					value_in));
			if (done) begin
				if (awaited_outcomes.size() == 0) begin
					$error("result word with no command outstanding");
					mismatches++;
				end else begin
					want = awaited_outcomes.pop_front();
					check_field("hit", 32'(want.hit), 32'(hit));
					check_field("evicted", 32'(want.evicted), 32'(evicted));
					check_field("evicted_key", 32'(want.ekey), 32'(evicted_key));
					check_field("evicted_value", 32'(want.evalue), 32'(evicted_value));
					check_field("occupancy", 32'(want.occ), 32'(occupancy));
				end
			end
			outstanding = awaited_outcomes.size();
		end
	end

endmodule

@@ dv/tb_lru_recency_list.sv @@
// Testbench top for lru_recency_list: clock, reset, command and config stimulus,
// watchdog and verdict. Depends on lrl_pkg, the RTL and lru_recency_list_checker.
module tb_lru_recency_list;

	localparam int QUIET_LIMIT = 1000;
	localparam int PHASES = 10;
	localparam int PHASE_WORDS = 65;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic                      cmd;
	logic [lrl_pkg::KEY_W-1:0] key_in;
	logic [lrl_pkg::VAL_W-1:0] value_in;
	logic                      done;
	logic                      hit;
	logic                      evicted;
	logic [lrl_pkg::KEY_W-1:0] evicted_key;
	logic [lrl_pkg::VAL_W-1:0] evicted_value;
	logic [lrl_pkg::CNT_W-1:0] occupancy;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [lrl_pkg::CNT_W-1:0] cfg_data;
	int                        mismatches;
	int                        outstanding;
	int                        quiet;

	lru_recency_list u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.key_in(key_in), .value_in(value_in), .done(done), .hit(hit),
		.evicted(evicted), .evicted_key(evicted_key), .evicted_value(evicted_value),
		.occupancy(occupancy), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	lru_recency_list_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.key_in(key_in), .value_in(value_in), .done(done), .hit(hit),
		.evicted(evicted), .evicted_key(evicted_key), .evicted_value(evicted_value),
		.occupancy(occupancy), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .mismatches(mismatches), .outstanding(outstanding)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Returns right after the accepting edge with start still high.
	task automatic issue(lrl_pkg::cmd_t op, logic [lrl_pkg::KEY_W-1:0] k,
			logic [lrl_pkg::VAL_W-1:0] v);
		@(negedge clk);
		start = 1'b1;
		cmd = op;
		key_in = k;
		value_in = v;
		do @(posedge clk); while (busy);
	endtask

	task automatic hold_off();
		@(negedge clk);
		start = 1'b0;
		cmd = 1'($urandom_range(0, 1));
		key_in = lrl_pkg::KEY_W'($urandom_range(0, 255));
		value_in = lrl_pkg::VAL_W'($urandom_range(0, 255));
	endtask

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic set_capacity(logic [lrl_pkg::CNT_W-1:0] c);
		drain();
		cfg_valid = 1'b1;
		cfg_data = c;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet <= 0;
		end else begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("lru_recency_list test failed");
				$finish;
			end
		end
	end

	initial begin
		logic [lrl_pkg::CNT_W-1:0] caps [PHASES];
		int idle_pct [PHASES];
		logic [lrl_pkg::KEY_W-1:0] key_pool [12];
		logic [lrl_pkg::KEY_W-1:0] k;
		lrl_pkg::cmd_t op;
		caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd2, 5'd17, 5'd8, 5'd12, 5'd16};
		idle_pct = '{0, 55, 19, 0, 55, 19, 55, 0, 19, 55};
		arst_n = 1'b0;
		start = 1'b0;
		cmd = lrl_pkg::CMD_TOUCH;
		key_in = '0;
		value_in = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: miss on an empty list, duplicates, hits at head and tail.
		issue(lrl_pkg::CMD_TOUCH, 8'h00, 8'h11);
		issue(lrl_pkg::CMD_INSERT, 8'h00, 8'hFF);
		issue(lrl_pkg::CMD_INSERT, 8'hFF, 8'h00);
		issue(lrl_pkg::CMD_INSERT, 8'h5A, 8'hA5);
		issue(lrl_pkg::CMD_INSERT, 8'h5A, 8'h3C);
		issue(lrl_pkg::CMD_TOUCH, 8'h5A, 8'h00);
		issue(lrl_pkg::CMD_TOUCH, 8'h00, 8'hFF);
		issue(lrl_pkg::CMD_TOUCH, 8'hFF, 8'h00);
		issue(lrl_pkg::CMD_TOUCH, 8'h77, 8'h00);
		// Capacity dropped under the count: each insert evicts just one entry.
		set_capacity(5'd1);
		issue(lrl_pkg::CMD_INSERT, 8'h81, 8'h18);
		issue(lrl_pkg::CMD_INSERT, 8'h42, 8'h24);
		issue(lrl_pkg::CMD_TOUCH, 8'h5A, 8'h00);
		set_capacity(5'd0);
		issue(lrl_pkg::CMD_INSERT, 8'h33, 8'hCC);
		issue(lrl_pkg::CMD_TOUCH, 8'h33, 8'h00);
		set_capacity(5'd31);
		issue(lrl_pkg::CMD_INSERT, 8'hFF, 8'hFF);
		issue(lrl_pkg::CMD_INSERT, 8'h00, 8'h00);
		set_capacity(5'd2);
		issue(lrl_pkg::CMD_INSERT, 8'hC3, 8'h3C);
		issue(lrl_pkg::CMD_TOUCH, 8'h00, 8'h00);
		issue(lrl_pkg::CMD_INSERT, 8'h99, 8'h66);

		foreach (key_pool[i])
			key_pool[i] = lrl_pkg::KEY_W'($urandom_range(0, 255));
		for (int p = 0; p < PHASES; p++) begin
			set_capacity(caps[p]);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (p == 2 && n == PHASE_WORDS / 2)
					drain();
				while ($urandom_range(0, 99) < idle_pct[p])
					hold_off();
				op = ($urandom_range(0, 99) < 55) ? lrl_pkg::CMD_INSERT : lrl_pkg::CMD_TOUCH;
				// Mostly a small key set so touches hit and duplicates pile up.
				if ($urandom_range(0, 99) < 80)
					k = key_pool[$urandom_range(0, 11)];
				else
					k = lrl_pkg::KEY_W'($urandom_range(0, 255));
				issue(op, k, lrl_pkg::VAL_W'($urandom_range(0, 255)));
			end
		end

		drain();
		repeat (5) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("lru_recency_list test passed");
		else
			$display("lru_recency_list test failed");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/lrl_pkg.sv
hw/rtl/lrl_cell.sv
hw/rtl/lru_recency_list.sv
dv/lru_recency_list_checker.sv
dv/tb_lru_recency_list.sv
